### hdl/zrle_pkg.sv
package zrle_pkg;

    localparam int LEN_BITS = 32;
    localparam int EXT_W    = LEN_BITS + 1;
    localparam int COUNT_W  = 15;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_LENGTH  = 2'd0,
        CFG_OUTPUT_LENGTH = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HDR_HI  = 2'd0,
        PH_HDR_LO  = 2'd1,
        PH_LITERAL = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LITERAL  = 2'd0,
        KIND_ZERO_RUN = 2'd1,
        KIND_DONE_OK  = 2'd2,
        KIND_DONE_ERR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_LEFTOVER  = 3'd3,
        ERR_TRUNCATED = 3'd4
    } t_err;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          data_byte;
        logic [COUNT_W-1:0]  zero_run;
        t_err                error_code;
        logic [31:0]         produced_length;
        logic                last_of_job;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_result_pair;

endpackage

### hdl/zrle_step.sv
module zrle_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [7:0]                          i_byte,
    input  logic [zrle_pkg::LEN_BITS-1:0]       i_ilen,
    input  logic [zrle_pkg::LEN_BITS-1:0]       i_olen,
    output zrle_pkg::t_result_pair              o_results
);

    zrle_pkg::t_phase                   r_phase, n_phase;
    logic [7:0]                         r_hdr_hi, n_hdr_hi;
    logic [zrle_pkg::COUNT_W-1:0]       r_lit_left, n_lit_left;
    logic [zrle_pkg::LEN_BITS-1:0]      r_in_pos, n_in_pos;
    logic [zrle_pkg::LEN_BITS-1:0]      r_out_pos, n_out_pos;
    logic                               r_failed, n_failed;
    zrle_pkg::t_err                     r_saved_err, n_saved_err;

    logic [zrle_pkg::LEN_BITS-1:0]      ilen_eff;
    logic [zrle_pkg::LEN_BITS-1:0]      in_pos_nx;
    logic [15:0]                        hdr;
    logic [zrle_pkg::COUNT_W-1:0]       cnt;
    logic [zrle_pkg::COUNT_W-1:0]       lit_dec;
    logic [zrle_pkg::EXT_W-1:0]         out_plus_cnt;
    logic [zrle_pkg::EXT_W-1:0]         in_plus_cnt;

    zrle_pkg::t_phase                   phase_mid;
    logic [zrle_pkg::COUNT_W-1:0]       lit_mid;
    logic [zrle_pkg::LEN_BITS-1:0]      out_mid;
    logic                               hdr_load;
    logic                               emit_run;
    logic                               emit_lit;
    zrle_pkg::t_err                     err_now;
    logic                               failed_mid;
    zrle_pkg::t_err                     err_mid;
    logic                               end_job;
    zrle_pkg::t_err                     end_err;
    logic                               fin_fail;
    zrle_pkg::t_err                     fin_err;
    zrle_pkg::t_result                  emit_res;
    zrle_pkg::t_result                  fin_res;

    assign ilen_eff     = (i_ilen == '0) ? (zrle_pkg::LEN_BITS)'(1) : i_ilen;
    assign in_pos_nx    = r_in_pos + (zrle_pkg::LEN_BITS)'(1);
    assign hdr          = {r_hdr_hi, i_byte};
    assign cnt          = hdr[zrle_pkg::COUNT_W-1:0];
    assign lit_dec      = r_lit_left - (zrle_pkg::COUNT_W)'(1);
    assign out_plus_cnt = {1'b0, r_out_pos} + (zrle_pkg::EXT_W)'(cnt);
    assign in_plus_cnt  = {1'b0, in_pos_nx} + (zrle_pkg::EXT_W)'(cnt);

    // byte handling for the current phase
    always_comb begin
        phase_mid = r_phase;
        lit_mid   = r_lit_left;
        out_mid   = r_out_pos;
        hdr_load  = 1'b0;
        emit_run  = 1'b0;
        emit_lit  = 1'b0;
        err_now   = zrle_pkg::ERR_NONE;
        if (!r_failed) begin
            case (r_phase)
                zrle_pkg::PH_HDR_LO: begin
                    phase_mid = zrle_pkg::PH_HDR_HI;
                    if (hdr[15]) begin
                        if (out_plus_cnt > {1'b0, i_olen}) begin
                            err_now = zrle_pkg::ERR_OVERFLOW;
                        end else begin
                            emit_run = 1'b1;
                            out_mid  = out_plus_cnt[zrle_pkg::LEN_BITS-1:0];
                        end
                    end else if (in_plus_cnt > {1'b0, ilen_eff}) begin
                        err_now = zrle_pkg::ERR_UNDERFLOW;
                    end else if (out_plus_cnt > {1'b0, i_olen}) begin
                        err_now = zrle_pkg::ERR_OVERFLOW;
                    end else begin
                        lit_mid = cnt;
                        if (cnt != '0) begin
                            phase_mid = zrle_pkg::PH_LITERAL;
                        end
                    end
                end
                zrle_pkg::PH_LITERAL: begin
                    emit_lit  = 1'b1;
                    out_mid   = r_out_pos + (zrle_pkg::LEN_BITS)'(1);
                    lit_mid   = lit_dec;
                    phase_mid = (lit_dec == '0) ? zrle_pkg::PH_HDR_HI : zrle_pkg::PH_LITERAL;
                end
                default: begin
                    phase_mid = zrle_pkg::PH_HDR_HI;
                    if (r_out_pos >= i_olen) begin
                        err_now = zrle_pkg::ERR_LEFTOVER;
                    end else begin
                        hdr_load  = 1'b1;
                        phase_mid = zrle_pkg::PH_HDR_LO;
                    end
                end
            endcase
        end
    end

    assign failed_mid = r_failed || (err_now != zrle_pkg::ERR_NONE);
    assign err_mid    = r_failed ? r_saved_err : err_now;
    assign end_job    = (in_pos_nx >= ilen_eff);

    // checks at the end of a job
    always_comb begin
        end_err = zrle_pkg::ERR_NONE;
        if (!failed_mid) begin
            case (phase_mid)
                zrle_pkg::PH_HDR_LO:  end_err = zrle_pkg::ERR_TRUNCATED;
                zrle_pkg::PH_LITERAL: end_err = zrle_pkg::ERR_UNDERFLOW;
                default: begin
                    if (out_mid < i_olen) begin
                        end_err = zrle_pkg::ERR_LEFTOVER;
                    end
                end
            endcase
        end
    end

    assign fin_fail = failed_mid || (end_err != zrle_pkg::ERR_NONE);
    assign fin_err  = failed_mid ? err_mid : end_err;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_hdr_hi    = r_hdr_hi;
        n_lit_left  = r_lit_left;
        n_in_pos    = r_in_pos;
        n_out_pos   = r_out_pos;
        n_failed    = r_failed;
        n_saved_err = r_saved_err;
        if (i_fire) begin
            if (end_job) begin
                n_phase     = zrle_pkg::PH_HDR_HI;
                n_hdr_hi    = '0;
                n_lit_left  = '0;
                n_in_pos    = '0;
                n_out_pos   = '0;
                n_failed    = 1'b0;
                n_saved_err = zrle_pkg::ERR_NONE;
            end else begin
                n_phase     = phase_mid;
                n_hdr_hi    = hdr_load ? i_byte : r_hdr_hi;
                n_lit_left  = lit_mid;
                n_in_pos    = in_pos_nx;
                n_out_pos   = out_mid;
                n_failed    = failed_mid;
                n_saved_err = err_mid;
            end
        end
    end

    // results of this beat
    always_comb begin
        emit_res                 = '0;
        emit_res.kind            = emit_run ? zrle_pkg::KIND_ZERO_RUN : zrle_pkg::KIND_LITERAL;
        emit_res.data_byte       = emit_lit ? i_byte : 8'd0;
        emit_res.zero_run        = emit_run ? cnt : '0;
        emit_res.error_code      = zrle_pkg::ERR_NONE;

        fin_res                  = '0;
        fin_res.kind             = fin_fail ? zrle_pkg::KIND_DONE_ERR : zrle_pkg::KIND_DONE_OK;
        fin_res.error_code       = fin_fail ? fin_err : zrle_pkg::ERR_NONE;
        fin_res.produced_length  = 32'(out_mid);
        fin_res.last_of_job      = 1'b1;

        o_results                = '0;
        o_results.count          = 2'(emit_run || emit_lit) + 2'(end_job);
        o_results.first          = (emit_run || emit_lit) ? emit_res : fin_res;
        o_results.second         = fin_res;
        if (!i_fire) begin
            o_results.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= zrle_pkg::PH_HDR_HI;
            r_hdr_hi    <= '0;
            r_lit_left  <= '0;
            r_in_pos    <= '0;
            r_out_pos   <= '0;
            r_failed    <= 1'b0;
            r_saved_err <= zrle_pkg::ERR_NONE;
        end else begin
            r_phase     <= n_phase;
            r_hdr_hi    <= n_hdr_hi;
            r_lit_left  <= n_lit_left;
            r_in_pos    <= n_in_pos;
            r_out_pos   <= n_out_pos;
            r_failed    <= n_failed;
            r_saved_err <= n_saved_err;
        end
    end

endmodule

### hdl/zrle_out_fifo.sv
module zrle_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  zrle_pkg::t_result_pair              i_push,
    input  logic                                i_pop,
    output logic                                o_room2,
    output logic                                o_valid,
    output zrle_pkg::t_result                   o_head
);

    zrle_pkg::t_result                  r_mem [zrle_pkg::FIFO_DEPTH];
    logic [zrle_pkg::FIFO_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [zrle_pkg::FIFO_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [zrle_pkg::FIFO_CNT_W-1:0]    r_count, n_count;
    logic [zrle_pkg::FIFO_PTR_W-1:0]    wr_ptr_b;
    logic                               pop_ok;

    assign o_valid  = (r_count != '0);
    assign o_room2  = (r_count <= (zrle_pkg::FIFO_CNT_W)'(zrle_pkg::FIFO_DEPTH - 2));
    assign o_head   = r_mem[r_rd_ptr];
    assign pop_ok   = i_pop && o_valid;
    assign wr_ptr_b = r_wr_ptr + (zrle_pkg::FIFO_PTR_W)'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + (zrle_pkg::FIFO_PTR_W)'(i_push.count);
        n_rd_ptr = r_rd_ptr + (zrle_pkg::FIFO_PTR_W)'(pop_ok);
        n_count  = r_count + (zrle_pkg::FIFO_CNT_W)'(i_push.count)
                   - (zrle_pkg::FIFO_CNT_W)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### hdl/zero_run_rle_decoder_core.sv
// Zero-run decoder core.
// Input channel: i_valid / o_stall carry one encoded byte per beat on
// i_code_byte. Output channel: o_valid / i_stall carry one result per beat
// (literal byte, zero run, or the final status of a job with
// o_produced_length and o_last_of_job set).
// Lengths are written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write them only while the block is idle, which the block
// itself does not enforce. Index 0 is input_length, index 1 output_length.
// An accepted byte waits in the input register, is decoded from it into
// the result queue, and its results leave the queue on the output.
// Throughput: one byte per cycle; a byte that ends a job and also yields a
// literal or zero run gives two results, which leave on successive beats.
// The rate is set by the four-entry result queue: a byte is decoded only
// when two entries are free, so a stalled receiver fills the queue and
// o_stall then rises; nothing is dropped.
// Reset (synchronous, active low) empties the queue, sets input_length to
// 1 and output_length to 0, and starts a fresh job.
module zero_run_rle_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_code_byte,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_kind,
    output logic [7:0]                          o_data_byte,
    output logic [14:0]                         o_zero_run,
    output logic [2:0]                          o_error_code,
    output logic [31:0]                         o_produced_length,
    output logic                                o_last_of_job,
    input  logic                                i_cfg_we,
    input  logic [zrle_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [zrle_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [31:0]                r_input_length;
    logic [31:0]                r_output_length;
    logic                       r_in_valid, n_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       fire;
    logic                       accept;
    logic                       room2;
    zrle_pkg::t_result_pair     results;
    zrle_pkg::t_result          head;

    assign fire    = r_in_valid && room2;
    assign o_stall = r_in_valid && !room2;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_input_length  <= 32'd1;
            r_output_length <= 32'd0;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    zrle_pkg::CFG_INPUT_LENGTH:  r_input_length  <= i_cfg_data;
                    zrle_pkg::CFG_OUTPUT_LENGTH: r_output_length <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_code_byte;
        end
    end

    zrle_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_ilen    ((zrle_pkg::LEN_BITS)'(r_input_length)),
        .i_olen    ((zrle_pkg::LEN_BITS)'(r_output_length)),
        .o_results (results)
    );

    zrle_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (results),
        .i_pop   (!i_stall),
        .o_room2 (room2),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_kind            = head.kind;
    assign o_data_byte       = head.data_byte;
    assign o_zero_run        = head.zero_run;
    assign o_error_code      = head.error_code;
    assign o_produced_length = head.produced_length;
    assign o_last_of_job     = head.last_of_job;

endmodule

### tb/zero_run_rle_decoder_core_tb.sv
`timescale 1ns / 100ps

module zero_run_rle_decoder_core_tb;

    localparam int LIMIT    = 400000;
    localparam int LAT_WAIT = 4;
    localparam int N_DIR    = 48;
    localparam int N_RANDOM = 1100;
    localparam int HOLD_CYC = 300;

    typedef enum logic [1:0] {
        ROW_BYTE    = 2'd0,
        ROW_CFG_IN  = 2'd1,
        ROW_CFG_OUT = 2'd2
    } t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic [31:0]        val;
        logic               chk;
        zrle_pkg::t_result  want;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [7:0]                     i_code_byte;
    logic                           o_valid;
    logic                           i_stall;
    logic [1:0]                     o_kind;
    logic [7:0]                     o_data_byte;
    logic [14:0]                    o_zero_run;
    logic [2:0]                     o_error_code;
    logic [31:0]                    o_produced_length;
    logic                           o_last_of_job;
    logic                           i_cfg_we;
    logic [zrle_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [zrle_pkg::CFG_W-1:0]     i_cfg_data;

    zero_run_rle_decoder_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_code_byte       (i_code_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_zero_run        (o_zero_run),
        .o_error_code      (o_error_code),
        .o_produced_length (o_produced_length),
        .o_last_of_job     (o_last_of_job),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // decoder model state
    logic [31:0]        dec_in_len   = 32'd1;
    logic [31:0]        dec_out_len  = 32'd0;
    zrle_pkg::t_phase   dec_phase    = zrle_pkg::PH_HDR_HI;
    logic [7:0]         dec_hdr_hi   = 8'd0;
    logic [14:0]        dec_lit_left = 15'd0;
    logic [63:0]        dec_in_pos   = 64'd0;
    logic [63:0]        dec_out_pos  = 64'd0;
    logic               dec_failed   = 1'b0;
    zrle_pkg::t_err     dec_err      = zrle_pkg::ERR_NONE;

    zrle_pkg::t_result  due_results [$];
    int                 fails = 0;
    int                 cycles = 0;
    bit                 no_idle = 1'b0;
    bit                 rx_hold_req = 1'b0;
    int                 rx_hold_left = 0;
    zrle_pkg::t_result  got;
    zrle_pkg::t_result  want;
    t_row               dir_steps [N_DIR];

    logic [7:0]  job_bytes [$];
    int unsigned out_total, seg_n, cnt, mode, n_send, reps, job_no, sent;
    logic [31:0] in_v, out_v;

    function automatic zrle_pkg::t_result mk_res(zrle_pkg::t_kind k, logic [7:0] d,
                                                 logic [14:0] z, zrle_pkg::t_err e,
                                                 logic [31:0] p, logic l);
        zrle_pkg::t_result r;
        r.kind            = k;
        r.data_byte       = d;
        r.zero_run        = z;
        r.error_code      = e;
        r.produced_length = p;
        r.last_of_job     = l;
        return r;
    endfunction

    function automatic t_row op_row(t_row_op op, logic [31:0] v);
        t_row r;
        r.op   = op;
        r.val  = v;
        r.chk  = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_row fin(logic [7:0] b, zrle_pkg::t_kind k, zrle_pkg::t_err e,
                                 logic [31:0] p);
        t_row r;
        r.op   = ROW_BYTE;
        r.val  = {24'd0, b};
        r.chk  = 1'b1;
        r.want = mk_res(k, 8'd0, 15'd0, e, p, 1'b1);
        return r;
    endfunction

    task automatic mark_fail(input zrle_pkg::t_err e);
        dec_failed = 1'b1;
        dec_err    = e;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [63:0] ilen;
        logic [15:0] hdr;
        ilen       = (dec_in_len == 32'd0) ? 64'd1 : {32'd0, dec_in_len};
        dec_in_pos = {32'd0, dec_in_pos[31:0] + 32'd1};
        hdr        = {dec_hdr_hi, b};
        if (!dec_failed) begin
            case (dec_phase)
                zrle_pkg::PH_HDR_LO: begin
                    dec_phase = zrle_pkg::PH_HDR_HI;
                    if (hdr[15]) begin
                        if (dec_out_pos + hdr[14:0] > {32'd0, dec_out_len}) begin
                            mark_fail(zrle_pkg::ERR_OVERFLOW);
                        end else begin
                            due_results.push_back(mk_res(zrle_pkg::KIND_ZERO_RUN, 8'd0,
                                                         hdr[14:0], zrle_pkg::ERR_NONE,
                                                         32'd0, 1'b0));
                            dec_out_pos = dec_out_pos + hdr[14:0];
                        end
                    end else if (dec_in_pos + hdr[14:0] > ilen) begin
                        mark_fail(zrle_pkg::ERR_UNDERFLOW);
                    end else if (dec_out_pos + hdr[14:0] > {32'd0, dec_out_len}) begin
                        mark_fail(zrle_pkg::ERR_OVERFLOW);
                    end else begin
                        dec_lit_left = hdr[14:0];
                        if (hdr[14:0] != 15'd0) dec_phase = zrle_pkg::PH_LITERAL;
                    end
                end
                zrle_pkg::PH_LITERAL: begin
                    due_results.push_back(mk_res(zrle_pkg::KIND_LITERAL, b, 15'd0,
                                                 zrle_pkg::ERR_NONE, 32'd0, 1'b0));
                    dec_out_pos  = dec_out_pos + 64'd1;
                    dec_lit_left = dec_lit_left - 15'd1;
                    if (dec_lit_left == 15'd0) dec_phase = zrle_pkg::PH_HDR_HI;
                end
                default: begin
                    dec_phase = zrle_pkg::PH_HDR_HI;
                    if (dec_out_pos >= {32'd0, dec_out_len}) begin
                        mark_fail(zrle_pkg::ERR_LEFTOVER);
                    end else begin
                        dec_hdr_hi = b;
                        dec_phase  = zrle_pkg::PH_HDR_LO;
                    end
                end
            endcase
        end
        if (dec_in_pos >= ilen) begin
            if (!dec_failed) begin
                if (dec_phase == zrle_pkg::PH_HDR_LO) mark_fail(zrle_pkg::ERR_TRUNCATED);
                else if (dec_phase == zrle_pkg::PH_LITERAL) mark_fail(zrle_pkg::ERR_UNDERFLOW);
                else if (dec_out_pos < {32'd0, dec_out_len}) mark_fail(zrle_pkg::ERR_LEFTOVER);
            end
            if (dec_failed)
                due_results.push_back(mk_res(zrle_pkg::KIND_DONE_ERR, 8'd0, 15'd0, dec_err,
                                             dec_out_pos[31:0], 1'b1));
            else
                due_results.push_back(mk_res(zrle_pkg::KIND_DONE_OK, 8'd0, 15'd0,
                                             zrle_pkg::ERR_NONE, dec_out_pos[31:0], 1'b1));
            dec_phase    = zrle_pkg::PH_HDR_HI;
            dec_hdr_hi   = 8'd0;
            dec_lit_left = 15'd0;
            dec_in_pos   = 64'd0;
            dec_out_pos  = 64'd0;
            dec_failed   = 1'b0;
            dec_err      = zrle_pkg::ERR_NONE;
        end
    endtask

    // valid stays high after the beat; the next call either moves on or drops it
    task automatic send_byte(input logic [7:0] b, input logic chk,
                             input zrle_pkg::t_result typed);
        while (!no_idle && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(b);
        if (chk) begin
            void'(due_results.pop_back());
            due_results.push_back(typed);
        end
    endtask

    task automatic settle();
        if (i_valid) i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input zrle_pkg::t_cfg_idx idx, input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == zrle_pkg::CFG_INPUT_LENGTH) dec_in_len = v;
        else dec_out_len = v;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check accepted beats, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = mk_res(zrle_pkg::t_kind'(o_kind), o_data_byte, o_zero_run,
                             zrle_pkg::t_err'(o_error_code), o_produced_length,
                             o_last_of_job);
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, kind %0d", $time, o_kind);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) fails++;
                    if (got.kind !== want.kind)
                        $display("%0t: kind expected %0d got %0d", $time,
                                 want.kind, got.kind);
                    if (got.data_byte !== want.data_byte)
                        $display("%0t: data_byte expected %0h got %0h", $time,
                                 want.data_byte, got.data_byte);
                    if (got.zero_run !== want.zero_run)
                        $display("%0t: zero_run expected %0d got %0d", $time,
                                 want.zero_run, got.zero_run);
                    if (got.error_code !== want.error_code)
                        $display("%0t: error_code expected %0d got %0d", $time,
                                 want.error_code, got.error_code);
                    if (got.produced_length !== want.produced_length)
                        $display("%0t: produced_length expected %0d got %0d", $time,
                                 want.produced_length, got.produced_length);
                    if (got.last_of_job !== want.last_of_job)
                        $display("%0t: last_of_job expected %0d got %0d", $time,
                                 want.last_of_job, got.last_of_job);
                end
            end
            if (rx_hold_req) begin
                rx_hold_left = HOLD_CYC;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left = rx_hold_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_idle && ($urandom_range(99) < 33);
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_code_byte = 8'd0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = zrle_pkg::CFG_INPUT_LENGTH;
        i_cfg_data  = '0;

        dir_steps = '{
            fin(8'h00, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_LEFTOVER, 32'd0),
            // output full: header arrives with capacity used up, rest dropped
            op_row(ROW_CFG_IN, 32'd4), op_row(ROW_CFG_OUT, 32'd2),
            op_row(ROW_BYTE, 32'h80), op_row(ROW_BYTE, 32'h02), op_row(ROW_BYTE, 32'h01),
            fin(8'hFF, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_LEFTOVER, 32'd2),
            // empty zero run, empty literal, then short output
            op_row(ROW_CFG_IN, 32'd4), op_row(ROW_CFG_OUT, 32'd1),
            op_row(ROW_BYTE, 32'h80), op_row(ROW_BYTE, 32'h00), op_row(ROW_BYTE, 32'h00),
            fin(8'h00, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_LEFTOVER, 32'd0),
            // odd trailing byte
            op_row(ROW_CFG_IN, 32'd3), op_row(ROW_CFG_OUT, 32'd8),
            op_row(ROW_BYTE, 32'h80), op_row(ROW_BYTE, 32'h07),
            fin(8'h12, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_TRUNCATED, 32'd7),
            op_row(ROW_CFG_IN, 32'd2), op_row(ROW_CFG_OUT, 32'd4),
            op_row(ROW_BYTE, 32'hFF),
            fin(8'hFF, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_OVERFLOW, 32'd0),
            op_row(ROW_CFG_IN, 32'd3), op_row(ROW_CFG_OUT, 32'd10),
            op_row(ROW_BYTE, 32'h00), op_row(ROW_BYTE, 32'h05),
            fin(8'h41, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_UNDERFLOW, 32'd0),
            // literal on the last byte: literal beat then status
            op_row(ROW_CFG_IN, 32'd5), op_row(ROW_CFG_OUT, 32'd3),
            op_row(ROW_BYTE, 32'h00), op_row(ROW_BYTE, 32'h03), op_row(ROW_BYTE, 32'h00),
            op_row(ROW_BYTE, 32'h80), op_row(ROW_BYTE, 32'hFF),
            // longest literal, then input length lowered below the count so far
            op_row(ROW_CFG_IN, 32'hFFFF_FFFF), op_row(ROW_CFG_OUT, 32'hFFFF_FFFF),
            op_row(ROW_BYTE, 32'h7F), op_row(ROW_BYTE, 32'hFF), op_row(ROW_BYTE, 32'h01),
            op_row(ROW_CFG_IN, 32'd2),
            op_row(ROW_BYTE, 32'h02),
            op_row(ROW_CFG_IN, 32'd2), op_row(ROW_CFG_OUT, 32'd32767),
            op_row(ROW_BYTE, 32'hFF), op_row(ROW_BYTE, 32'hFF),
            // zero input length counts as one
            op_row(ROW_CFG_IN, 32'd0), op_row(ROW_CFG_OUT, 32'd0),
            fin(8'h5A, zrle_pkg::KIND_DONE_ERR, zrle_pkg::ERR_LEFTOVER, 32'd0)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            case (dir_steps[k].op)
                ROW_CFG_IN: begin
                    settle();
                    cfg_write(zrle_pkg::CFG_INPUT_LENGTH, dir_steps[k].val);
                end
                ROW_CFG_OUT: begin
                    settle();
                    cfg_write(zrle_pkg::CFG_OUTPUT_LENGTH, dir_steps[k].val);
                end
                default: send_byte(dir_steps[k].val[7:0], dir_steps[k].chk, dir_steps[k].want);
            endcase
        end

        sent   = 0;
        job_no = 0;
        while (sent < N_RANDOM) begin
            job_bytes.delete();
            out_total = 0;
            seg_n = $urandom_range(6, 1);
            for (int s = 0; s < seg_n; s++) begin
                if ($urandom_range(1)) begin
                    cnt = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(40);
                    job_bytes.push_back({1'b1, cnt[14:8]});
                    job_bytes.push_back(cnt[7:0]);
                end else begin
                    cnt = $urandom_range(12);
                    job_bytes.push_back({1'b0, cnt[14:8]});
                    job_bytes.push_back(cnt[7:0]);
                    for (int j = 0; j < cnt; j++) job_bytes.push_back(8'($urandom_range(255)));
                end
                out_total += cnt;
            end
            in_v   = job_bytes.size();
            out_v  = out_total;
            n_send = job_bytes.size();
            mode   = (job_no == 10) ? 0 : $urandom_range(99);
            if (mode >= 55 && mode < 65) begin
                out_v = out_total + $urandom_range(4, 1);
            end else if (mode >= 65 && mode < 72) begin
                out_v = (out_total == 0) ? 32'd0 : $urandom_range(out_total - 1);
            end else if (mode >= 72 && mode < 82) begin
                in_v   = $urandom_range(job_bytes.size(), 1);
                n_send = in_v;
            end else if (mode >= 82 && mode < 88) begin
                job_bytes.push_back(8'($urandom_range(255)));
                in_v   = job_bytes.size();
                n_send = in_v;
            end else if (mode >= 88 && mode < 96) begin
                job_bytes.delete();
                n_send = $urandom_range(16, 1);
                for (int j = 0; j < n_send; j++) job_bytes.push_back(8'($urandom_range(255)));
                in_v  = (n_send == 1 && $urandom_range(1)) ? 32'd0 : n_send;
                out_v = $urandom_range(64);
            end else if (mode >= 96) begin
                out_v = 32'hFFFF_FFFF;
            end
            reps = (job_no == 10) ? 3 : $urandom_range(3, 1);

            settle();
            cfg_write(zrle_pkg::CFG_INPUT_LENGTH, in_v);
            cfg_write(zrle_pkg::CFG_OUTPUT_LENGTH, out_v);
            job_no++;
            no_idle = (job_no >= 20 && job_no < 28);
            if (job_no == 11) rx_hold_req = 1'b1;
            repeat (reps) begin
                for (int j = 0; j < n_send; j++) begin
                    send_byte(job_bytes[j], 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (fails == 0 && due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hdl/zrle_pkg.sv
hdl/zrle_step.sv
hdl/zrle_out_fifo.sv
hdl/zero_run_rle_decoder_core.sv
tb/zero_run_rle_decoder_core_tb.sv
